// ===== rtl/feature_zscore_normalizer_unit_defines.svh =====
// Assertion macros used by the feature z-score normaliser top level.
`ifndef FEATURE_ZSCORE_NORMALIZER_UNIT_DEFINES_SVH
`define FEATURE_ZSCORE_NORMALIZER_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define FZN_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define FZN_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/fzn_pkg.sv =====
// Package of constants and codes for the feature z-score normaliser.
package fzn_pkg;
  localparam int MAX_FEATURES = 16;
  localparam int MAX_SAMPLES  = 1024;
  localparam int ADDR_W  = $clog2(MAX_SAMPLES);
  localparam int CNT_W   = ADDR_W + 1;
  localparam int COL_W   = $clog2(MAX_FEATURES);
  localparam int FC_W    = 5;
  localparam int SMP_W   = 16;
  localparam int SUM_W   = 27;
  localparam int DNUM_W  = 48;
  localparam int DDEN_W  = 17;
  localparam int ROOT_W  = DNUM_W / 2;

  localparam logic [1:0] CMD_PUSH  = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_FULL   = 2'd1;
  localparam logic [1:0] ST_EMPTY  = 2'd2;
  localparam logic [1:0] ST_NOROW  = 2'd3;
endpackage

// ===== rtl/fzn_channels.sv =====
// Valid/ready channel interfaces for commands and results.
interface fzn_in_if;
  logic              valid;
  logic              ready;
  logic [1:0]        cmd;
  logic signed [15:0] sample;
  modport source(output valid, cmd, sample, input ready);
  modport sink(input valid, cmd, sample, output ready);
endinterface

interface fzn_out_if;
  logic              valid;
  logic              ready;
  logic signed [15:0] norm_value;
  logic              last_element;
  logic [1:0]        status;
  modport source(output valid, norm_value, last_element, status, input ready);
  modport sink(input valid, norm_value, last_element, status, output ready);
endinterface

// ===== rtl/feature_zscore_normalizer_unit.sv =====
// Top level of the feature z-score normaliser.
//
// Commands arrive one transaction at a time on in_ch (push a Q8.8 sample,
// read the next normalised element, clear, or no operation) and every
// command yields exactly one result transaction on out_ch carrying a
// Q4.12 value, a last-element flag and a status code. cfg_we with cfg_data
// sets the number of features per row and must only be used while idle.
// A push or clear goes from acceptance through the emit state into the
// output register. A read when statistics are current runs the scaled
// division on the shared 48-step restoring divider. The first read after
// the data set changes also runs the statistics pass: a row count
// division, then, if there is at least one row, per feature two passes
// over the sample memory (address and data states per row, then address,
// data and accumulate states per row), two divisions and a square root.
// The sample store is a simple dual-port RAM with a registered read;
// pushes and statistics reads never overlap, so no forwarding is required.
// Reset empties the data set and sets one feature per row; no clearing
// pass runs. A finished result sits in the output register while the next
// command is accepted, and the block stalls only when a second result is
// ready before the receiver has taken the first.
module feature_zscore_normalizer_unit (
  input  logic                    clk,
  input  logic                    rst_n,
  fzn_in_if.sink                  in_ch,
  fzn_out_if.source               out_ch,
  input  logic                    cfg_we,
  input  logic [fzn_pkg::FC_W-1:0] cfg_data
);
  import fzn_pkg::*;

  `include "feature_zscore_normalizer_unit_defines.svh"

  localparam logic [4:0] S_IDLE     = 5'd0;
  localparam logic [4:0] S_ROWS     = 5'd1;
  localparam logic [4:0] S_COL      = 5'd2;
  localparam logic [4:0] S_P1_ADDR  = 5'd3;
  localparam logic [4:0] S_P1_DATA  = 5'd4;
  localparam logic [4:0] S_MEAN     = 5'd5;
  localparam logic [4:0] S_P2_ADDR  = 5'd6;
  localparam logic [4:0] S_P2_DATA  = 5'd7;
  localparam logic [4:0] S_P2_ACC   = 5'd8;
  localparam logic [4:0] S_VAR      = 5'd9;
  localparam logic [4:0] S_SQRT     = 5'd10;
  localparam logic [4:0] S_RD_CHECK = 5'd11;
  localparam logic [4:0] S_RD_WAIT  = 5'd12;
  localparam logic [4:0] S_RD_DATA  = 5'd13;
  localparam logic [4:0] S_RD_DIV   = 5'd14;
  localparam logic [4:0] S_EMIT     = 5'd15;

  logic [4:0]               state_r;
  logic [FC_W-1:0]          fc_r;
  logic [FC_W-1:0]          fc_eff;
  logic [CNT_W-1:0]         count_r;
  logic [CNT_W-1:0]         rpos_r;
  logic [COL_W-1:0]         rcol_r;
  logic                     ready_r;
  logic [CNT_W-1:0]         rows_r;
  logic [CNT_W+FC_W-1:0]    total;
  logic [FC_W-1:0]          col_r;
  logic [CNT_W-1:0]         row_r;
  logic [CNT_W-1:0]         addr_r;
  logic signed [SUM_W-1:0]  sum_r;
  logic signed [SUM_W-1:0]  sum_nxt;
  logic [DNUM_W-1:0]        ssd_r;
  logic [2*SMP_W+1:0]       prod_r;
  logic signed [SMP_W-1:0]  mean_cur_r;
  logic signed [SMP_W-1:0]  mean_r [MAX_FEATURES];
  logic [SMP_W-1:0]         dev_r [MAX_FEATURES];
  logic                     neg_r;

  logic signed [SMP_W-1:0]  res_val_r;
  logic                     res_last_r;
  logic [1:0]               res_stat_r;
  logic                     out_valid_r;
  logic signed [SMP_W-1:0]  out_val_r;
  logic                     out_last_r;
  logic [1:0]               out_stat_r;

  logic                     div_start_r;
  logic [DNUM_W-1:0]        div_num_r;
  logic [DDEN_W-1:0]        div_den_r;
  logic                     div_done;
  logic [DNUM_W-1:0]        div_quo;
  logic                     sqrt_start_r;
  logic                     sqrt_done;
  logic [ROOT_W-1:0]        sqrt_root;

  logic                     mem_we;
  logic [SMP_W-1:0]         mem_rdata;
  logic                     in_acc;
  logic                     emit_go;
  logic signed [SMP_W:0]    diff;
  logic [SMP_W:0]           diff_mag;
  logic [SUM_W-1:0]         sum_mag;
  logic [SMP_W-1:0]         dev_cur;
  logic signed [SMP_W-1:0]  mean_rd;

  assign fc_eff = (fc_r == '0) ? FC_W'(1) :
                  (fc_r > FC_W'(MAX_FEATURES)) ? FC_W'(MAX_FEATURES) : fc_r;
  assign total   = rows_r * fc_eff;
  assign in_acc  = in_ch.valid && in_ch.ready;
  assign emit_go = (state_r == S_EMIT) && (!out_valid_r || out_ch.ready);
  assign mem_we  = in_acc && (in_ch.cmd == CMD_PUSH) && (count_r < CNT_W'(MAX_SAMPLES));
  assign mean_rd = mean_r[rcol_r];
  assign dev_cur = dev_r[rcol_r];
  assign diff    = (state_r == S_RD_DATA) ?
                   $signed({mem_rdata[SMP_W-1], mem_rdata}) -
                   $signed({mean_rd[SMP_W-1], mean_rd}) :
                   $signed({mem_rdata[SMP_W-1], mem_rdata}) -
                   $signed({mean_cur_r[SMP_W-1], mean_cur_r});
  assign diff_mag = diff[SMP_W] ? (SMP_W+1)'(-diff) : diff;
  // The column sum including the sample that arrives this cycle.
  assign sum_nxt  = sum_r + SUM_W'($signed(mem_rdata));
  assign sum_mag  = sum_nxt[SUM_W-1] ? SUM_W'(-sum_nxt) : sum_nxt;

  fzn_ram #(.WIDTH(SMP_W), .DEPTH(MAX_SAMPLES)) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (count_r[ADDR_W-1:0]),
    .wdata (in_ch.sample),
    .raddr (addr_r[ADDR_W-1:0]),
    .rdata (mem_rdata)
  );

  fzn_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start_r),
    .num   (div_num_r),
    .den   (div_den_r),
    .done  (div_done),
    .quo   (div_quo)
  );

  fzn_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sqrt_start_r),
    .radicand (div_quo),
    .done     (sqrt_done),
    .root     (sqrt_root)
  );

  // Control state: sequencer, counters and the output register valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      fc_r         <= FC_W'(1);
      count_r      <= '0;
      rpos_r       <= '0;
      rcol_r       <= '0;
      ready_r      <= 1'b0;
      out_valid_r  <= 1'b0;
      div_start_r  <= 1'b0;
      sqrt_start_r <= 1'b0;
    end else begin
      div_start_r  <= 1'b0;
      sqrt_start_r <= 1'b0;
      if (emit_go) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        fc_r    <= cfg_data;
        ready_r <= 1'b0;
        rpos_r  <= '0;
        rcol_r  <= '0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            state_r <= S_EMIT;
            case (in_ch.cmd)
              CMD_PUSH: begin
                if (mem_we) begin
                  count_r <= count_r + CNT_W'(1);
                  ready_r <= 1'b0;
                  rpos_r  <= '0;
                  rcol_r  <= '0;
                end
              end
              CMD_READ: begin
                if (ready_r) begin
                  state_r <= S_RD_CHECK;
                end else begin
                  div_start_r <= 1'b1;
                  state_r     <= S_ROWS;
                end
              end
              CMD_CLEAR: begin
                count_r <= '0;
                rpos_r  <= '0;
                rcol_r  <= '0;
                ready_r <= 1'b0;
              end
              default: begin
              end
            endcase
          end
        end
        S_ROWS: begin
          if (div_done) begin
            state_r <= (div_quo[CNT_W-1:0] == '0) ? S_EMIT : S_COL;
          end
        end
        S_COL:     state_r <= S_P1_ADDR;
        S_P1_ADDR: state_r <= S_P1_DATA;
        S_P1_DATA: begin
          if (row_r + CNT_W'(1) == rows_r) begin
            div_start_r <= 1'b1;
            state_r     <= S_MEAN;
          end else begin
            state_r <= S_P1_ADDR;
          end
        end
        S_MEAN: begin
          if (div_done) begin
            state_r <= S_P2_ADDR;
          end
        end
        S_P2_ADDR: state_r <= S_P2_DATA;
        S_P2_DATA: state_r <= S_P2_ACC;
        S_P2_ACC: begin
          if (row_r + CNT_W'(1) == rows_r) begin
            div_start_r <= 1'b1;
            state_r     <= S_VAR;
          end else begin
            state_r <= S_P2_ADDR;
          end
        end
        S_VAR: begin
          if (div_done) begin
            sqrt_start_r <= 1'b1;
            state_r      <= S_SQRT;
          end
        end
        S_SQRT: begin
          if (sqrt_done) begin
            if (col_r + FC_W'(1) == fc_eff) begin
              ready_r <= 1'b1;
              state_r <= S_RD_CHECK;
            end else begin
              state_r <= S_COL;
            end
          end
        end
        S_RD_CHECK: begin
          state_r <= ({{FC_W{1'b0}}, rpos_r} >= total) ? S_EMIT : S_RD_WAIT;
        end
        S_RD_WAIT: state_r <= S_RD_DATA;
        S_RD_DATA: begin
          div_start_r <= 1'b1;
          state_r     <= S_RD_DIV;
        end
        S_RD_DIV: begin
          if (div_done) begin
            rpos_r  <= rpos_r + CNT_W'(1);
            rcol_r  <= ({1'b0, rcol_r} + FC_W'(1) == fc_eff) ? '0 : rcol_r + COL_W'(1);
            state_r <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (emit_go) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Datapath registers: no reset needed.
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        res_val_r  <= '0;
        res_last_r <= 1'b0;
        res_stat_r <= ST_OK;
        if (in_acc && in_ch.cmd == CMD_PUSH && !mem_we) begin
          res_stat_r <= ST_FULL;
        end
        div_num_r <= DNUM_W'(count_r);
        div_den_r <= DDEN_W'(fc_eff);
      end
      S_ROWS: begin
        if (div_done) begin
          rows_r <= div_quo[CNT_W-1:0];
          col_r  <= '0;
          if (div_quo[CNT_W-1:0] == '0) begin
            res_stat_r <= ST_NOROW;
          end
        end
      end
      S_COL: begin
        sum_r  <= '0;
        row_r  <= '0;
        addr_r <= CNT_W'(col_r);
      end
      S_P1_DATA: begin
        sum_r  <= sum_nxt;
        addr_r <= addr_r + CNT_W'(fc_eff);
        row_r  <= row_r + CNT_W'(1);
        div_num_r <= DNUM_W'({sum_mag, 1'b0}) + DNUM_W'(rows_r);
        div_den_r <= DDEN_W'({rows_r, 1'b0});
        neg_r     <= sum_nxt[SUM_W-1];
      end
      S_MEAN: begin
        // Restore the sign of the finished sum for rounding away from zero.
        if (div_done) begin
          mean_cur_r <= neg_r ? SMP_W'(-div_quo[SMP_W-1:0]) : div_quo[SMP_W-1:0];
          mean_r[col_r[COL_W-1:0]] <= neg_r ? SMP_W'(-div_quo[SMP_W-1:0]) :
                                      div_quo[SMP_W-1:0];
          ssd_r  <= '0;
          row_r  <= '0;
          addr_r <= CNT_W'(col_r);
        end
      end
      S_P2_DATA: begin
        prod_r <= (2*SMP_W+2)'(diff * diff);
      end
      S_P2_ACC: begin
        ssd_r  <= ssd_r + DNUM_W'(prod_r);
        addr_r <= addr_r + CNT_W'(fc_eff);
        row_r  <= row_r + CNT_W'(1);
        div_num_r <= ssd_r + DNUM_W'(prod_r);
        div_den_r <= DDEN_W'(rows_r);
      end
      S_SQRT: begin
        if (sqrt_done) begin
          dev_r[col_r[COL_W-1:0]] <= (sqrt_root == '0) ? SMP_W'(256) :
                                     (sqrt_root > ROOT_W'(16'hFFFF)) ? 16'hFFFF :
                                     sqrt_root[SMP_W-1:0];
          col_r <= col_r + FC_W'(1);
        end
      end
      S_RD_CHECK: begin
        addr_r <= rpos_r;
        if ({{FC_W{1'b0}}, rpos_r} >= total) begin
          res_stat_r <= ST_EMPTY;
        end
      end
      S_RD_DATA: begin
        div_num_r <= DNUM_W'({diff_mag, 13'b0}) + DNUM_W'(dev_cur);
        div_den_r <= {dev_cur, 1'b0};
        neg_r     <= diff[SMP_W];
      end
      S_RD_DIV: begin
        if (div_done) begin
          if (neg_r) begin
            res_val_r <= (div_quo > DNUM_W'(32768)) ? 16'sh8000 : SMP_W'(-div_quo[SMP_W-1:0]);
          end else begin
            res_val_r <= (div_quo > DNUM_W'(32767)) ? 16'sh7FFF : div_quo[SMP_W-1:0];
          end
          res_last_r <= ({{FC_W{1'b0}}, rpos_r} + (CNT_W+FC_W)'(1) == total);
        end
      end
      default: begin
      end
    endcase
    if (emit_go) begin
      out_val_r  <= res_val_r;
      out_last_r <= res_last_r;
      out_stat_r <= res_stat_r;
    end
  end

  assign in_ch.ready         = (state_r == S_IDLE);
  assign out_ch.valid        = out_valid_r;
  assign out_ch.norm_value   = out_val_r;
  assign out_ch.last_element = out_last_r;
  assign out_ch.status       = out_stat_r;

  `FZN_ASSERT_IMP(a_count_bound, 1'b1, count_r <= CNT_W'(MAX_SAMPLES), "sample count overflow")
  `FZN_ASSERT_IMP(a_rpos_bound, ready_r, {{FC_W{1'b0}}, rpos_r} <= total, "read beyond data set")
  `FZN_ASSERT_IMP(a_rcol_bound, 1'b1, {1'b0, rcol_r} < fc_eff, "read column out of range")
  `FZN_ASSERT_NEXT(a_emit_valid, emit_go, out_valid_r, "result not presented")
  `FZN_ASSERT_IMP(a_div_owner, div_done,
    state_r == S_ROWS || state_r == S_MEAN || state_r == S_VAR || state_r == S_RD_DIV,
    "divider finished outside a wait state")
endmodule

// ===== rtl/fzn_ram.sv =====
// Generic single-port-write, registered-read synchronous RAM.
module fzn_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/fzn_div.sv =====
// Iterative restoring divider, one quotient bit per cycle.
module fzn_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [fzn_pkg::DNUM_W-1:0]  num,
  input  logic [fzn_pkg::DDEN_W-1:0]  den,
  output logic                        done,
  output logic [fzn_pkg::DNUM_W-1:0]  quo
);
  import fzn_pkg::*;

  logic                busy_r;
  logic                done_r;
  logic [5:0]          cnt_r;
  logic [DNUM_W-1:0]   quo_r;
  logic [DDEN_W-1:0]   rem_r;
  logic [DDEN_W-1:0]   den_r;
  logic [DDEN_W:0]     trial;
  logic                fits;

  assign trial = {rem_r, quo_r[DNUM_W-1]};
  assign fits  = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'(DNUM_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= num;
      rem_r <= '0;
      den_r <= den;
    end else if (busy_r) begin
      if (fits) begin
        rem_r <= DDEN_W'(trial - {1'b0, den_r});
      end else begin
        rem_r <= trial[DDEN_W-1:0];
      end
      quo_r <= {quo_r[DNUM_W-2:0], fits};
    end
  end

  assign done = done_r;
  assign quo  = quo_r;
endmodule

// ===== rtl/fzn_sqrt.sv =====
// Iterative integer square root, two radicand bits per cycle.
module fzn_sqrt (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [fzn_pkg::DNUM_W-1:0]  radicand,
  output logic                        done,
  output logic [fzn_pkg::ROOT_W-1:0]  root
);
  import fzn_pkg::*;

  logic              busy_r;
  logic              done_r;
  logic [4:0]        cnt_r;
  logic [DNUM_W-1:0] v_r;
  logic [DNUM_W-1:0] res_r;
  logic [DNUM_W-1:0] bit_r;
  logic [DNUM_W-1:0] trial;

  assign trial = res_r + bit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'(ROOT_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      v_r   <= radicand;
      res_r <= '0;
      bit_r <= {2'b01, {(DNUM_W-2){1'b0}}};
    end else if (busy_r) begin
      if (v_r >= trial) begin
        v_r   <= v_r - trial;
        res_r <= (res_r >> 1) + bit_r;
      end else begin
        res_r <= res_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
  end

  assign done = done_r;
  assign root = res_r[ROOT_W-1:0];
endmodule
